[sv/binomial_coefficient_unit_assert.svh]
// Assertion macros for the binomial coefficient unit checker.
// Plain text macros only; included by the files that assert.
`ifndef BINOMIAL_COEFFICIENT_UNIT_ASSERT_SVH
`define BINOMIAL_COEFFICIENT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bcu assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bcu assertion failed");

`endif

[sv/bcu_pkg.sv]
// Shared types and widths for the binomial coefficient unit.
// No dependencies; imported by the divider and the top level.
package bcu_pkg;

	localparam int N_W    = 7;              // width of n and k
	localparam int KK_W   = 6;              // reduced k, at most 33
	localparam int COEF_W = 63;             // coefficient width
	localparam int PROD_W = COEF_W + N_W;   // running value times (n - i)
	localparam int DIV_W  = 7;              // divisor (i + 1)
	localparam int CNT_W  = $clog2(PROD_W + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} bcu_state_t;

endpackage

[sv/binomial_coefficient_unit.sv]
// Binomial coefficient unit, top level: sequencer, multiplier and output register.
// Depends on bcu_pkg and bcu_div.
//
//   channel   dir   fields (low bit first)                 accept
//   s_axis    in    tdata: n_total[6:0] k_chosen[13:7]    tvalid & tready
//   m_axis    out   tdata: coefficient[62:0]; tuser: oor  tvalid & tready
//
// Steps: an item with reduced k = min(k, n-k) runs k steps, each one multiply
//   state (ST_MUL) followed by a serial divide and its done strobe (ST_DIV),
//   so k = 33 is the longest case. The serial divider sets the time per step.
// Special cases (n above MAX_N, k above n, reduced k of zero) go straight to ST_FIN.
// Reset clears the sequencer and output valid; no clearing pass.
// A finished result waits in the output register; the next beat is accepted
// while it waits, but a second result stalls in ST_FIN until the first is taken.
module binomial_coefficient_unit
	import bcu_pkg::*;
#(
	parameter int MAX_N = 66
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // n_total[6:0], k_chosen[13:7], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // coefficient[62:0], zero pad
	output logic [0:0]  m_axis_tuser    // out_of_range[0]
);

	localparam logic [N_W-1:0] MaxNV = N_W'(MAX_N);

	bcu_state_t state_q, state_d;

	logic [N_W-1:0]    n_q;
	logic [KK_W-1:0]   kk_q;
	logic [KK_W-1:0]   i_q;
	logic [COEF_W-1:0] val_q;
	logic              oor_q;

	logic              out_valid_q;
	logic [COEF_W-1:0] out_coef_q;
	logic              out_oor_q;

	// input decode
	logic [N_W-1:0]    n_in;
	logic [N_W-1:0]    k_in;
	logic              in_oor;
	logic              in_kbig;
	logic [N_W-1:0]    kk_full;
	logic [KK_W-1:0]   kk_in;
	logic              in_short;

	// control
	logic              acc;
	logic              div_start;
	logic              div_done;
	logic              step_last;
	logic              fin_load;
	logic [PROD_W-1:0] product;
	logic [DIV_W-1:0]  divisor;
	logic [PROD_W-1:0] quotient;
	logic [N_W-1:0]    mult;

	always_comb begin
		n_in     = s_axis_tdata[6:0];
		k_in     = s_axis_tdata[13:7];
		in_oor   = n_in > MaxNV;
		in_kbig  = k_in > n_in;
		// fold k onto the smaller side
		kk_full  = (({1'b0, k_in} + {1'b0, k_in}) > {1'b0, n_in}) ? (n_in - k_in) : k_in;
		kk_in    = kk_full[KK_W-1:0];
		in_short = in_oor || in_kbig || (kk_in == '0);
	end

	assign acc       = s_axis_tvalid && s_axis_tready;
	assign step_last = (i_q + KK_W'(1)) == kk_q;
	assign mult      = n_q - N_W'(i_q);
	assign product   = PROD_W'(val_q) * PROD_W'(mult);
	assign divisor   = DIV_W'(i_q) + DIV_W'(1);

	bcu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc)
					state_d = in_short ? ST_FIN : ST_MUL;
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done)
					state_d = step_last ? ST_FIN : ST_MUL;
			end
			ST_FIN: begin
				if (!out_valid_q || m_axis_tready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		div_start     = 1'b0;
		fin_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: s_axis_tready = 1'b1;
			ST_MUL:  div_start     = 1'b1;
			ST_DIV:  ;
			ST_FIN:  fin_load      = !out_valid_q || m_axis_tready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin_load)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath: load on accept, update once per finished divide
	always_ff @(posedge clk) begin
		if (acc) begin
			n_q   <= n_in;
			kk_q  <= kk_in;
			i_q   <= '0;
			oor_q <= in_oor;
			val_q <= (in_oor || in_kbig) ? '0 : COEF_W'(1);
		end else if (state_q == ST_DIV && div_done) begin
			val_q <= quotient[COEF_W-1:0];
			i_q   <= i_q + KK_W'(1);
		end
		if (fin_load) begin
			out_coef_q <= val_q;
			out_oor_q  <= oor_q;
		end
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {1'b0, out_coef_q};
	assign m_axis_tuser[0] = out_oor_q;

endmodule

[sv/bcu_div.sv]
// Serial restoring divider: one quotient bit per cycle.
// Depends on bcu_pkg for widths.
module bcu_div
	import bcu_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [DIV_W-1:0]  divisor,
	output logic              done,
	output logic [PROD_W-1:0] quotient
);

	logic [PROD_W-1:0] quo_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;

	logic [DIV_W:0]    trial;
	logic              ge;
	logic [DIV_W:0]    diff;

	always_comb begin
		trial = {rem_q, quo_q[PROD_W-1]};
		ge    = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(PROD_W);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (cnt_q != '0)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			// shift in next dividend bit, subtract when it fits
			quo_q <= {quo_q[PROD_W-2:0], ge};
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

[sv/bcu_checker.sv]
// Port-level checker for the binomial coefficient unit, bound to the top level.
// Depends on binomial_coefficient_unit_assert.svh.
`include "binomial_coefficient_unit_assert.svh"

module bcu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [15:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic [0:0]  m_axis_tuser
);

	logic        s_beat;
	logic        s_stall;
	logic [16:0] in_word;
	logic        out_stall;
	logic [65:0] out_word;

	assign s_beat    = s_axis_tvalid && s_axis_tready;
	assign s_stall   = s_axis_tvalid && !s_axis_tready;
	assign in_word   = {s_axis_tvalid, s_axis_tdata};
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_word  = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};

	// a stalled result beat holds
`BCU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, $stable(out_word))
	// a stalled input beat holds
`BCU_ASSERT_NEXT(a_in_hold, clk, arst_n, s_stall, $stable(in_word))
	// range flag always comes with a zero coefficient
`BCU_ASSERT_IMPL(a_oor_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 64'd0)
	// not ready in the cycle after taking an item
`BCU_ASSERT_NEXT(a_busy_after, clk, arst_n, s_beat, !s_axis_tready)
	// pad bit above the coefficient stays clear
`BCU_ASSERT_IMPL(a_pad_zero, clk, arst_n, m_axis_tvalid, !m_axis_tdata[63])

endmodule

bind binomial_coefficient_unit bcu_checker u_bcu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
